FILE: rtl/random_permutation_generator_assert.svh
// Assertion macros for the permutation generator
`ifndef RANDOM_PERMUTATION_GENERATOR_ASSERT_SVH
`define RANDOM_PERMUTATION_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition must hold at every edge outside reset
`define RPG_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define RPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RPG_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define RPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/rpg_pkg.sv
`default_nettype none

package rpg_pkg;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int ENTRY_W = 10;
  localparam int CFG_W   = 11;
  localparam int STAT_W  = 2;
  localparam int LCG_W   = 32;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ITEM_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] ITEM_COUNT_RST = 11'd8;

  // Default store depth
  localparam int DEF_MAX_ITEMS = 1024;

  // Generator constants
  localparam logic [LCG_W-1:0] LCG_SEED = 32'h1234_5678;
  localparam logic [LCG_W-1:0] LCG_MUL  = 32'd1664525;
  localparam logic [LCG_W-1:0] LCG_ADD  = 32'd1013904223;

  // Request opcodes
  localparam logic OP_GEN  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_COUNT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_READ   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/rpg_req_if.sv
`default_nettype none

interface rpg_req_if import rpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [IDX_W-1:0] read_index;

  modport source (output valid, output opcode, output read_index, input ready);
  modport sink   (input valid, input opcode, input read_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpg_rsp_if.sv
`default_nettype none

interface rpg_rsp_if import rpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_value;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output entry_value, output status, input ready);
  modport sink   (input valid, input entry_value, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/random_permutation_generator.sv
// Random permutation generator. A generate request reseeds a 32-bit LCG,
// writes the identity 0..n-1 into a single-port-read, single-port-write store
// of MAX_ITEMS entries (n = item_count, capped at MAX_ITEMS) and runs a
// Fisher-Yates shuffle from the top entry down; a read request returns one
// entry of the last permutation with status ok, or status 2 if nothing has
// been generated or the index is at or beyond that count. A generate with
// item_count zero returns status 1 and leaves everything untouched. Every
// request yields exactly one response. A generate runs an identity fill at one
// store write per cycle, then per position one LCG step, one divider start, a
// wait on the bit-serial modulo unit and four store accesses (read, read,
// write, write) through the single read and single write port. No clearing
// pass is needed after reset. item_count lives at byte address 0 of the APB
// port; pready is always high.
`default_nettype none

`include "random_permutation_generator_assert.svh"

module random_permutation_generator import rpg_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rpg_req_if.sink                    req,
  rpg_rsp_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_FILL   = 11'b000_0000_0010,
    S_LCG    = 11'b000_0000_0100,
    S_START  = 11'b000_0000_1000,
    S_DIV    = 11'b000_0001_0000,
    S_RDA    = 11'b000_0010_0000,
    S_RDB    = 11'b000_0100_0000,
    S_WRA    = 11'b000_1000_0000,
    S_WRB    = 11'b001_0000_0000,
    S_READ   = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   item_count;
  logic               gen_flag;
  logic [CW-1:0]      gen_count;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      count_capped;
  logic [ENTRY_W-1:0] held;
  logic [ENTRY_W-1:0] res_value;
  logic [STAT_W-1:0]  res_status;
  logic               out_valid;
  logic [ENTRY_W-1:0] out_value;
  logic [STAT_W-1:0]  out_status;
  logic               out_load;
  logic               accept;
  logic               rd_ok;
  logic               slot_free;
  logic               cfg_write;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;

  logic [LCG_W-1:0]   lcg_value;
  logic               lcg_seed;
  logic               lcg_step;
  logic               div_start;
  logic               div_busy;
  logic [AW-1:0]      pick;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ITEM_COUNT) ? APB_DATA_W'(item_count) : '0;

  // Request and response handshake
  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = out_valid;
  assign rsp.entry_value = out_value;
  assign rsp.status      = out_status;
  assign slot_free       = !out_valid || rsp.ready;
  assign out_load        = ((state == S_READ) || (state == S_FINISH)) && slot_free;

  // Cap the count at the store depth, check reads against the last good count
  always_comb begin
    if (32'(item_count) > 32'(MAX_ITEMS)) begin
      count_capped = CW'(MAX_ITEMS);
    end else begin
      count_capped = CW'(item_count);
    end
    rd_ok = gen_flag && (CMP_W'(req.read_index) < CMP_W'(gen_count));
  end

  assign lcg_seed  = accept && (req.opcode == OP_GEN) && (item_count != '0);
  assign lcg_step  = (state == S_LCG);
  assign div_start = (state == S_START);

  // Store access per state
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(pos);
    mem_wr_data = ENTRY_W'(pos);
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(pos);
    unique case (state)
      S_IDLE: begin
        mem_rd_en   = accept && (req.opcode == OP_READ) && rd_ok;
        mem_rd_addr = AW'(req.read_index);
      end
      S_FILL: begin
        mem_wr_en = 1'b1;
      end
      S_RDA: begin
        mem_rd_en = 1'b1;
      end
      S_RDB: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = pick;
      end
      S_WRA: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
      end
      S_WRB: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pick;
        mem_wr_data = held;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, result hold and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gen_flag   <= 1'b0;
      gen_count  <= '0;
      out_valid  <= 1'b0;
      item_count <= ITEM_COUNT_RST;
    end else begin
      if (cfg_write && (paddr[2] == REG_ITEM_COUNT)) begin
        item_count <= pwdata[CFG_W-1:0];
      end
      // Load the response register, or drop a response once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            if (req.opcode == OP_GEN) begin
              if (item_count == '0) begin
                res_status <= ST_ZERO_COUNT;
                state      <= S_FINISH;
              end else begin
                gen_count <= count_capped;
                gen_flag  <= 1'b1;
                pos       <= '0;
                state     <= S_FILL;
              end
            end else if (rd_ok) begin
              state <= S_READ;
            end else begin
              res_status <= ST_BAD_READ;
              state      <= S_FINISH;
            end
          end
        end
        S_FILL: begin
          if (pos == CW'(gen_count - 1'b1)) begin
            if (pos == '0) begin
              res_value  <= '0;
              res_status <= ST_OK;
              state      <= S_FINISH;
            end else begin
              state <= S_LCG;
            end
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_LCG: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          held  <= mem_rd_data;
          state <= S_WRA;
        end
        S_WRA: begin
          state <= S_WRB;
        end
        S_WRB: begin
          if (pos == CW'(1)) begin
            res_value  <= '0;
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else begin
            pos   <= pos - 1'b1;
            state <= S_LCG;
          end
        end
        S_READ: begin
          if (slot_free) begin
            out_value  <= mem_rd_data;
            out_status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            res_value  <= mem_rd_data;
            res_status <= ST_OK;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rpg_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rpg_lcg u_lcg (
    .clk       (clk),
    .rst       (rst),
    .seed_load (lcg_seed),
    .step      (lcg_step),
    .value     (lcg_value)
  );

  rpg_mod_unit #(
    .DIV_W (CW),
    .REM_W (AW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (lcg_value),
    .divisor   (CW'(pos + 1'b1)),
    .busy      (div_busy),
    .remainder (pick)
  );

  // Checks on the sequencer
  `RPG_ASSERT_HOLDS(a_div_in_state, clk, rst, !div_busy || state == S_DIV, "divider busy outside its wait state")
  `RPG_ASSERT_HOLDS(a_pick_in_range, clk, rst, state != S_RDA || CW'(pick) <= pos, "swap partner above position")
  `RPG_ASSERT_HOLDS(a_count_bound, clk, rst, 32'(gen_count) <= 32'(MAX_ITEMS), "generated count above depth")
  `RPG_ASSERT_NEXT(a_gen_fills, clk, rst, accept && req.opcode == OP_GEN && item_count != '0, state == S_FILL, "generate did not start fill")

endmodule

`default_nettype wire

FILE: rtl/rpg_store.sv
`default_nettype none

module rpg_store import rpg_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ITEMS,
  parameter int AW    = $clog2(DEF_MAX_ITEMS)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output      logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rpg_lcg.sv
`default_nettype none

module rpg_lcg import rpg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             seed_load,
  input  wire logic             step,
  output      logic [LCG_W-1:0] value
);

  // Reseed or advance x' = x * MUL + ADD, modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= LCG_SEED;
    end else if (seed_load) begin
      value <= LCG_SEED;
    end else if (step) begin
      value <= LCG_W'(value * LCG_MUL + LCG_ADD);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rpg_mod_unit.sv
`default_nettype none

module rpg_mod_unit import rpg_pkg::*; #(
  parameter int DIV_W = 11,
  parameter int REM_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [LCG_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output      logic             busy,
  output      logic [REM_W-1:0] remainder
);

  localparam int STEP_W = $clog2(LCG_W + 1);

  logic [LCG_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[LCG_W-1]};
    diff  = trial - {1'b0, divisor};
    take  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      quo   <= dividend;
      rem   <= '0;
      steps <= STEP_W'(LCG_W);
      busy  <= 1'b1;
    end else if (busy) begin
      quo   <= {quo[LCG_W-2:0], 1'b0};
      rem   <= take ? DIV_W'(diff) : DIV_W'(trial);
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder stays below the divisor, so it fits the index width
  assign remainder = REM_W'(rem);

endmodule

`default_nettype wire

FILE: test/tb_random_permutation_generator.sv
`timescale 1ns / 1ps

module tb_random_permutation_generator;
  import rpg_pkg::*;

  localparam int PERM_DEPTH = DEF_MAX_ITEMS;
  localparam logic [APB_ADDR_W-1:0] ADDR_ITEM_COUNT = APB_ADDR_W'(4 * int'(REG_ITEM_COUNT));
  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TARGET_REQUESTS = 1900;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct {
    logic             opcode;
    logic [IDX_W-1:0] read_index;
    bit               after_drain;
  } perm_req_t;

  typedef struct {
    logic [ENTRY_W-1:0] entry_value;
    logic [STAT_W-1:0]  status;
  } perm_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rpg_req_if req_if ();
  rpg_rsp_if rsp_if ();

  random_permutation_generator #(
    .MAX_ITEMS(PERM_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Mirror of the block's state and configuration
  logic [ENTRY_W-1:0] perm_mirror [PERM_DEPTH];
  logic [LCG_W-1:0] lcg_mirror;
  bit has_perm;
  int unsigned perm_len;
  logic [CFG_W-1:0] count_mirror;

  perm_req_t request_backlog[$];
  perm_result_t pending_results[$];
  perm_result_t want;

  bit req_took;
  bit rsp_took;
  int quiet_cycles;
  int fail_count;
  int idle_mode;
  int hold_off_asks;
  int hold_off_seen;
  int hold_left;

  int n_generates;
  int n_zero_count;
  int n_reads;
  int n_bad_reads;
  int widest_perm;

  // Compute the response to one request and advance the mirrored state
  function automatic perm_result_t shuffle_predict(logic op, logic [IDX_W-1:0] idx);
    int unsigned n;
    int unsigned pos;
    int unsigned pick;
    logic [ENTRY_W-1:0] held;
    perm_result_t res;
    res.entry_value = '0;
    res.status = ST_OK;
    if (op == OP_GEN) begin
      if (count_mirror == 0) begin
        res.status = ST_ZERO_COUNT;
      end else begin
        n = (count_mirror > PERM_DEPTH) ? PERM_DEPTH : count_mirror;
        lcg_mirror = LCG_SEED;
        for (pos = 0; pos < n; pos++) perm_mirror[pos] = ENTRY_W'(pos);
        for (pos = n - 1; pos > 0; pos--) begin
          lcg_mirror = lcg_mirror * LCG_MUL + LCG_ADD;
          pick = lcg_mirror % (pos + 1);
          held = perm_mirror[pos];
          perm_mirror[pos] = perm_mirror[pick];
          perm_mirror[pick] = held;
        end
        has_perm = 1'b1;
        perm_len = n;
      end
    end else if (!has_perm || idx >= perm_len) begin
      res.status = ST_BAD_READ;
    end else begin
      res.entry_value = perm_mirror[idx];
    end
    return res;
  endfunction

  function automatic int sender_idle_pct();
    return (idle_mode == 0) ? 33 : (idle_mode == 1) ? 49 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (idle_mode == 0) ? 49 : (idle_mode == 1) ? 33 : 0;
  endfunction

  // Clock, and known values on every input from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_GEN;
    req_if.read_index = '0;
    rsp_if.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // Request driver: hold an offered request until taken, else offer the next
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_took) begin
      req_if.valid <= 1'b1;
    end else if (request_backlog.size() > 0 &&
                 !(request_backlog[0].after_drain && pending_results.size() > 0) &&
                 $urandom_range(99) >= sender_idle_pct()) begin
      req_if.valid <= 1'b1;
      req_if.opcode <= request_backlog[0].opcode;
      req_if.read_index <= request_backlog[0].read_index;
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Response receiver: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (hold_off_asks != hold_off_seen) begin
      hold_off_seen <= hold_off_asks;
      hold_left <= HOLD_OFF_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Sample both handshakes: predict on request, check on response
  always @(posedge clk) begin
    if (rst) begin
      req_took = 1'b0;
      rsp_took = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_took = req_if.valid && req_if.ready;
      rsp_took = rsp_if.valid && rsp_if.ready;
      if (req_took) begin
        pending_results.push_back(shuffle_predict(req_if.opcode, req_if.read_index));
        if (req_if.opcode == OP_GEN) begin
          n_generates++;
          if (count_mirror == 0) n_zero_count++;
          else if (perm_len > widest_perm) widest_perm = perm_len;
        end else begin
          n_reads++;
          if (pending_results[$].status == ST_BAD_READ) n_bad_reads++;
        end
        void'(request_backlog.pop_front());
      end
      if (rsp_took) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES)
            $display("unexpected response: entry_value %0d status %0d",
                     rsp_if.entry_value, rsp_if.status);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.entry_value !== want.entry_value || rsp_if.status !== want.status) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
              $display("mismatch: entry_value %0d (expected %0d) status %0d (expected %0d)",
                       rsp_if.entry_value, want.entry_value, rsp_if.status, want.status);
          end
        end
      end
      quiet_cycles = (req_took || rsp_took) ? 0 : quiet_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void add_request(logic op, int unsigned idx, bit after_drain);
    perm_req_t item;
    item.opcode = op;
    item.read_index = IDX_W'(idx);
    item.after_drain = after_drain;
    request_backlog.push_back(item);
  endfunction

  task automatic write_item_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ITEM_COUNT;
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_mirror = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every request has been taken and answered
  task automatic drain();
    while (request_backlog.size() != 0 || pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int seg;
    int seg_len;
    int roll;
    int unsigned live_len;
    logic [CFG_W-1:0] next_count;
    count_mirror = ITEM_COUNT_RST;
    lcg_mirror = LCG_SEED;
    has_perm = 1'b0;
    perm_len = 0;
    idle_mode = 0;
    hold_off_asks = 0;
    hold_off_seen = 0;
    hold_left = 0;
    fail_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reads before any generate, then the reset count of eight
    add_request(OP_READ, 0, 1'b0);
    add_request(OP_READ, 1023, 1'b0);
    add_request(OP_GEN, 1023, 1'b0);
    for (int i = 0; i < 8; i++) add_request(OP_READ, i, 1'b0);
    add_request(OP_READ, 8, 1'b0);
    add_request(OP_READ, 1023, 1'b0);
    drain();

    // Zero count leaves the previous permutation readable
    write_item_count(0);
    add_request(OP_GEN, 0, 1'b0);
    add_request(OP_READ, 7, 1'b0);
    add_request(OP_READ, 8, 1'b0);
    drain();

    // Single element: no swaps at all
    write_item_count(1);
    add_request(OP_GEN, 512, 1'b0);
    add_request(OP_READ, 0, 1'b0);
    add_request(OP_READ, 1, 1'b0);
    drain();

    // Count above the store depth saturates, then the exact full depth
    write_item_count({CFG_W{1'b1}});
    add_request(OP_GEN, 0, 1'b0);
    add_request(OP_READ, 1023, 1'b0);
    add_request(OP_READ, 0, 1'b0);
    drain();
    write_item_count(11'(PERM_DEPTH));
    add_request(OP_GEN, 1023, 1'b0);
    add_request(OP_READ, 1023, 1'b0);
    add_request(OP_READ, 512, 1'b0);
    drain();
    live_len = perm_len;

    // Random segments: one count each, a generate then mostly legal reads
    seg = 0;
    while (n_generates + n_reads < TARGET_REQUESTS + 25) begin
      idle_mode = (n_generates + n_reads < 660) ? 0 :
                  (n_generates + n_reads < 1300) ? 1 : 2;
      roll = $urandom_range(99);
      if (roll < 4) next_count = 0;
      else if (roll < 10) next_count = 1;
      else if (roll < 90) next_count = CFG_W'($urandom_range(40, 2));
      else next_count = CFG_W'($urandom_range(160, 41));
      write_item_count(next_count);
      if (next_count != 0) live_len = (next_count > PERM_DEPTH) ? PERM_DEPTH : next_count;
      add_request(OP_GEN, $urandom_range(1023), 1'b0);
      seg_len = $urandom_range(80, 40);
      for (int k = 0; k < seg_len; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) add_request(OP_GEN, $urandom_range(1023), k == 30);
        else if (roll < 15) add_request(OP_READ, $urandom_range(1023), k == 30);
        else add_request(OP_READ, $urandom_range(live_len - 1), k == 30);
      end
      drain();

      // Stall the response side while reads keep coming
      if (seg == 4 || seg == 24) begin
        for (int k = 0; k < 60; k++) add_request(OP_READ, $urandom_range(live_len - 1), 1'b0);
        hold_off_asks++;
        drain();
      end
      seg++;
    end

    // Let any stray response show up before the verdict
    repeat (50) @(negedge clk);
    $display("covered %0d generates (%0d with zero count, widest %0d entries)",
             n_generates, n_zero_count, widest_perm);
    $display("and %0d reads (%0d rejected) under three idling patterns", n_reads, n_bad_reads);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("failures: %0d", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rpg_pkg.sv
rtl/rpg_req_if.sv
rtl/rpg_rsp_if.sv
rtl/rpg_store.sv
rtl/rpg_lcg.sv
rtl/rpg_mod_unit.sv
rtl/random_permutation_generator.sv
test/tb_random_permutation_generator.sv
